[rtl/core/vgrt_pkg.sv]
// Shared types, constants and codes for the voxel grid ray traversal block.
package vgrt_pkg;

    localparam int GRID_X_MAX_DEF   = 128;
    localparam int GRID_Y_MAX_DEF   = 128;
    localparam int GRID_Z_MAX_DEF   = 64;
    localparam int TEXTURE_BITS_DEF = 8;
    localparam int STEP_GUARD_DEF   = 100000;

    localparam int CFG_IDX_W = 3;
    localparam int CELL_W    = 35;
    localparam int CNT_W     = 11;
    localparam int T_W       = 63;

    localparam logic [T_W-1:0] T_CAP    = {1'b0, {(T_W-1){1'b1}}};
    localparam logic [T_W-1:0] T_INF    = {1'b1, {(T_W-1){1'b0}}};
    localparam logic [30:0]    DIST_MAX = 31'h7FFF_FFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RAY   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_SIZE = 3'd0,
        CFG_ORIGIN_X  = 3'd1,
        CFG_ORIGIN_Y  = 3'd2,
        CFG_ORIGIN_Z  = 3'd3,
        CFG_CELLS_X   = 3'd4,
        CFG_CELLS_Y   = 3'd5,
        CFG_CELLS_Z   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic               operation;
        logic [19:0]        voxel_address;
        logic               voxel_solid;
        logic [7:0]         voxel_texture;
        logic signed [31:0] ray_origin_x;
        logic signed [31:0] ray_origin_y;
        logic signed [31:0] ray_origin_z;
        logic signed [15:0] ray_dir_x;
        logic signed [15:0] ray_dir_y;
        logic signed [15:0] ray_dir_z;
        logic [30:0]        max_range;
    } item_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
        logic [7:0]  hit_texture;
    } result_t;

    typedef struct packed {
        logic [30:0]        cell_size;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic [7:0]         cells_x;
        logic [7:0]         cells_y;
        logic [6:0]         cells_z;
    } cfg_t;

    typedef struct packed {
        logic  wr_ok;
        item_t item;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } fe_out_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } bk_stat_t;

    typedef enum logic {
        DS_DIV  = 1'b0,
        DS_SQRT = 1'b1
    } ds_mode_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT_W,
        ST_CDIV,
        ST_CDIV_W,
        ST_MULA,
        ST_TN,
        ST_TN_W,
        ST_MULS,
        ST_TS,
        ST_TS_W,
        ST_W_CHK,
        ST_W_RD,
        ST_W_TEST,
        ST_W_SEL,
        ST_W_ADV,
        ST_DONE
    } bk_state_t;

endpackage

[rtl/core/voxel_grid_ray_traversal.sv]
// A write passes the queue, then the back end writes it to the map. A ray runs the
// squares of the direction, a 32-step root, a cell divide per axis, two more 48-step
// divides per moving axis, then voxel steps (with a map read when the voxel lies in the
// grid) and the result; one request is worked at a time, two more may wait queued.
// Results are one-cycle strobes on done; the receiver cannot stall.
// After reset the map is swept to zero, one voxel a cycle.
module voxel_grid_ray_traversal #(
    parameter int GRID_X_MAX   = vgrt_pkg::GRID_X_MAX_DEF,
    parameter int GRID_Y_MAX   = vgrt_pkg::GRID_Y_MAX_DEF,
    parameter int GRID_Z_MAX   = vgrt_pkg::GRID_Z_MAX_DEF,
    parameter int TEXTURE_BITS = vgrt_pkg::TEXTURE_BITS_DEF,
    parameter int STEP_GUARD   = vgrt_pkg::STEP_GUARD_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  vgrt_pkg::item_t                    item,
    output logic                               done,
    output vgrt_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vgrt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);

    vgrt_pkg::cfg_t     cfg_reg;
    vgrt_pkg::fe_out_t  fe;
    vgrt_pkg::bk_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_size <= 31'd65536;
            cfg_reg.origin_x  <= '0;
            cfg_reg.origin_y  <= '0;
            cfg_reg.origin_z  <= '0;
            cfg_reg.cells_x   <= 8'd128;
            cfg_reg.cells_y   <= 8'd128;
            cfg_reg.cells_z   <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vgrt_pkg::CFG_CELL_SIZE: cfg_reg.cell_size <= cfg_data[30:0];
                vgrt_pkg::CFG_ORIGIN_X:  cfg_reg.origin_x  <= cfg_data;
                vgrt_pkg::CFG_ORIGIN_Y:  cfg_reg.origin_y  <= cfg_data;
                vgrt_pkg::CFG_ORIGIN_Z:  cfg_reg.origin_z  <= cfg_data;
                vgrt_pkg::CFG_CELLS_X:   cfg_reg.cells_x   <= cfg_data[7:0];
                vgrt_pkg::CFG_CELLS_Y:   cfg_reg.cells_y   <= cfg_data[7:0];
                vgrt_pkg::CFG_CELLS_Z:   cfg_reg.cells_z   <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    vgrt_front #(
        .GRID_X_MAX (GRID_X_MAX),
        .GRID_Y_MAX (GRID_Y_MAX),
        .GRID_Z_MAX (GRID_Z_MAX)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .stat  (stat),
        .fe    (fe)
    );

    vgrt_back #(
        .GRID_X_MAX   (GRID_X_MAX),
        .GRID_Y_MAX   (GRID_Y_MAX),
        .GRID_Z_MAX   (GRID_Z_MAX),
        .TEXTURE_BITS (TEXTURE_BITS),
        .STEP_GUARD   (STEP_GUARD)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fe     (fe),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

[rtl/core/vgrt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vgrt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/vgrt_divsqrt.sv]
// Shared iterative unit: restoring divider (one bit a cycle) and integer square root.
module vgrt_divsqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  vgrt_pkg::ds_mode_t mode,
    input  logic [47:0]        num,
    input  logic [31:0]        den,
    input  logic [31:0]        rad,
    output logic               done,
    output logic [47:0]        quo,
    output logic [31:0]        rem,
    output logic [31:0]        root
);

    logic               busy_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    vgrt_pkg::ds_mode_t mode_reg;
    logic [47:0]        acc_reg;
    logic [33:0]        rem_reg;
    logic [31:0]        den_reg;
    logic [31:0]        root_reg;
    logic [31:0]        rad_reg;

    logic [32:0] d_sh;
    logic        d_ge;
    logic [32:0] d_rem;
    logic [35:0] s_sh;
    logic [35:0] s_trial;
    logic        s_ge;
    logic [35:0] s_rem;

    always_comb
    begin
        d_sh    = {rem_reg[31:0], acc_reg[47]};
        d_ge    = d_sh >= {1'b0, den_reg};
        d_rem   = d_ge ? (d_sh - {1'b0, den_reg}) : d_sh;
        s_sh    = {rem_reg, rad_reg[31:30]};
        s_trial = {2'b00, root_reg, 2'b01};
        s_ge    = s_sh >= s_trial;
        s_rem   = s_ge ? (s_sh - s_trial) : s_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (mode == vgrt_pkg::DS_SQRT) ? 6'd31 : 6'd47;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mode_reg <= mode;
            acc_reg  <= num;
            den_reg  <= den;
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (mode_reg == vgrt_pkg::DS_SQRT)
            begin
                rem_reg  <= s_rem[33:0];
                root_reg <= {root_reg[30:0], s_ge};
                rad_reg  <= {rad_reg[29:0], 2'b00};
            end
            else
            begin
                rem_reg <= {1'b0, d_rem};
                acc_reg <= {acc_reg[46:0], d_ge};
            end
        end
    end

    assign done = done_reg;
    assign quo  = acc_reg;
    assign rem  = rem_reg[31:0];
    assign root = root_reg;

endmodule

[rtl/core/vgrt_front.sv]
// Front end: takes requests, classifies them and holds them in a two-entry queue.
module vgrt_front #(
    parameter int GRID_X_MAX = vgrt_pkg::GRID_X_MAX_DEF,
    parameter int GRID_Y_MAX = vgrt_pkg::GRID_Y_MAX_DEF,
    parameter int GRID_Z_MAX = vgrt_pkg::GRID_Z_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  vgrt_pkg::item_t     item,
    input  vgrt_pkg::bk_stat_t  stat,
    output vgrt_pkg::fe_out_t   fe
);

    localparam longint MAP_DEPTH = longint'(GRID_X_MAX) * GRID_Y_MAX * GRID_Z_MAX;

    vgrt_pkg::entry_t q_reg [2];
    logic             rd_reg;
    logic             wr_reg;
    logic [1:0]       cnt_reg;
    logic             push;
    logic             pop;
    vgrt_pkg::entry_t ent;

    always_comb
    begin
        ent.item  = item;
        ent.wr_ok = (item.operation == vgrt_pkg::OP_WRITE) &&
                    (64'(item.voxel_address) < 64'(MAP_DEPTH));
    end

    assign busy     = (cnt_reg == 2'd2) || stat.clearing;
    assign push     = start && !busy;
    assign pop      = stat.pop && (cnt_reg != 2'd0);
    assign fe.valid = cnt_reg != 2'd0;
    assign fe.entry = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= ent;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue did not grow on push");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !push)
        else $error("request taken during clearing pass");

endmodule

[rtl/core/vgrt_back.sv]
// Back end: map clear after reset, voxel map writes, ray setup (norm, cell, boundary distances) and grid walk.
module vgrt_back #(
    parameter int GRID_X_MAX   = vgrt_pkg::GRID_X_MAX_DEF,
    parameter int GRID_Y_MAX   = vgrt_pkg::GRID_Y_MAX_DEF,
    parameter int GRID_Z_MAX   = vgrt_pkg::GRID_Z_MAX_DEF,
    parameter int TEXTURE_BITS = vgrt_pkg::TEXTURE_BITS_DEF,
    parameter int STEP_GUARD   = vgrt_pkg::STEP_GUARD_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vgrt_pkg::cfg_t      cfg,
    input  vgrt_pkg::fe_out_t   fe,
    output vgrt_pkg::bk_stat_t  stat,
    output logic                done,
    output vgrt_pkg::result_t   result
);

    localparam int MAP_DEPTH = GRID_X_MAX * GRID_Y_MAX * GRID_Z_MAX;
    localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int GW        = $clog2(STEP_GUARD + 1);
    localparam int RW        = TEXTURE_BITS + 1;
    localparam int CW        = vgrt_pkg::CELL_W;
    localparam int NW        = vgrt_pkg::CNT_W;
    localparam int TW        = vgrt_pkg::T_W;

    vgrt_pkg::bk_state_t state_reg;
    vgrt_pkg::bk_state_t state_next;
    logic [AW-1:0]       clr_addr_reg;

    logic signed [31:0]  pos_reg [3];
    logic signed [15:0]  dir_reg [3];
    logic [30:0]         maxr_reg;
    logic [31:0]         sumsq_reg;
    logic [63:0]         prod_reg;
    logic [31:0]         lenq_reg;
    logic [1:0]          k_reg;
    logic [30:0]         a_reg;
    logic signed [CW-1:0] cell_reg [3];
    logic [TW-1:0]       tn_reg [3];
    logic [TW-1:0]       ts_reg [3];
    logic [TW-1:0]       t_reg;
    logic [GW-1:0]       guard_reg;
    logic [AW-1:0]       addr_reg;
    logic [1:0]          ax_reg;
    logic                hit_reg;
    logic [30:0]         dist_reg;
    logic [7:0]          tex_reg;

    // datapath helpers
    logic [30:0]         cs;
    logic [NW-1:0]       ncell [3];
    logic [1:0]          kk;
    logic signed [15:0]  dir_k;
    logic [15:0]         ad_k;
    logic                dir_pos;
    logic                dir_zero;
    logic signed [31:0]  org_k;
    logic signed [32:0]  q;
    logic [32:0]         q_abs;
    logic                rem_nz;
    logic [CW-1:0]       c_mag;
    logic signed [CW-1:0] c_val;
    logic [30:0]         r_val;
    logic [30:0]         a_val;
    logic [31:0]         op_a;
    logic [31:0]         op_b;
    logic [31:0]         sumsq_sum;
    logic                in_grid;
    logic                leave;
    logic [31:0]         idx;
    logic [1:0]          ax_val;
    logic [TW:0]         tn_sum;
    logic [RW-1:0]       wr_word;
    logic [7:0]          rd_tex;
    logic                fin_miss;
    logic                fin_hit;
    logic                walk_init;

    logic                ds_go;
    vgrt_pkg::ds_mode_t  ds_mode;
    logic [47:0]         ds_num;
    logic [31:0]         ds_den;
    logic                ds_done;
    logic [47:0]         ds_quo;
    logic [31:0]         ds_rem;
    logic [31:0]         ds_root;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [RW-1:0]       ram_wdata;
    logic                ram_re;
    logic [RW-1:0]       ram_rdata;

    assign cs = (cfg.cell_size == 31'd0) ? 31'd1 : cfg.cell_size;

    always_comb
    begin
        ncell[0] = (NW'(cfg.cells_x) > NW'(GRID_X_MAX)) ? NW'(GRID_X_MAX) : NW'(cfg.cells_x);
        ncell[1] = (NW'(cfg.cells_y) > NW'(GRID_Y_MAX)) ? NW'(GRID_Y_MAX) : NW'(cfg.cells_y);
        ncell[2] = (NW'(cfg.cells_z) > NW'(GRID_Z_MAX)) ? NW'(GRID_Z_MAX) : NW'(cfg.cells_z);
    end

    // per-axis setup values
    always_comb
    begin
        kk       = (k_reg == 2'd3) ? 2'd2 : k_reg;
        dir_k    = dir_reg[kk];
        ad_k     = dir_k[15] ? 16'(-dir_k) : dir_k;
        dir_zero = dir_k == 16'sd0;
        dir_pos  = !dir_k[15] && !dir_zero;
        case (kk)
            2'd0:    org_k = cfg.origin_x;
            2'd1:    org_k = cfg.origin_y;
            default: org_k = cfg.origin_z;
        endcase
        q      = $signed({pos_reg[kk][31], pos_reg[kk]}) - $signed({org_k[31], org_k});
        q_abs  = q[32] ? 33'(-q) : q;
        rem_nz = ds_rem != 32'd0;
        // round the magnitude up only below the origin (floor of a negative offset)
        c_mag  = CW'(ds_quo[33:0]) + CW'(q[32] && rem_nz);
        c_val  = q[32] ? $signed(-c_mag) : $signed(c_mag);
        if (q[32])
        begin
            r_val = rem_nz ? (cs - ds_rem[30:0]) : 31'd0;
        end
        else
        begin
            r_val = ds_rem[30:0];
        end
        a_val     = dir_pos ? (cs - r_val) : r_val;
        sumsq_sum = sumsq_reg + prod_reg[31:0];
    end

    // walk helpers
    always_comb
    begin
        in_grid = 1'b1;
        leave   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (cell_reg[i] < 0 || cell_reg[i] >= $signed({{(CW-NW){1'b0}}, ncell[i]}))
            begin
                in_grid = 1'b0;
            end
            if ((cell_reg[i] < 0 && (dir_reg[i] <= 16'sd0)) ||
                (cell_reg[i] >= $signed({{(CW-NW){1'b0}}, ncell[i]}) &&
                 (dir_reg[i] >= 16'sd0)))
            begin
                leave = 1'b1;
            end
        end
        idx = (32'(cell_reg[2][NW-1:0]) * 32'(GRID_Y_MAX) + 32'(cell_reg[1][NW-1:0]))
              * 32'(GRID_X_MAX) + 32'(cell_reg[0][NW-1:0]);
        if (tn_reg[0] < tn_reg[1] && tn_reg[0] < tn_reg[2])
        begin
            ax_val = 2'd0;
        end
        else if (tn_reg[1] < tn_reg[2])
        begin
            ax_val = 2'd1;
        end
        else
        begin
            ax_val = 2'd2;
        end
        tn_sum = {1'b0, tn_reg[ax_reg]} + {1'b0, ts_reg[ax_reg]};
    end

    // texture lane widths
    always_comb
    begin
        wr_word     = '0;
        wr_word[RW-1] = fe.entry.item.voxel_solid;
        for (int i = 0; i < TEXTURE_BITS; i++)
        begin
            if (i < 8)
            begin
                wr_word[i] = fe.entry.item.voxel_texture[i];
            end
        end
        rd_tex = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < TEXTURE_BITS)
            begin
                rd_tex[i] = ram_rdata[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stat       = '0;
        ds_go      = 1'b0;
        ds_mode    = vgrt_pkg::DS_DIV;
        ds_num     = '0;
        ds_den     = 32'd1;
        ram_we     = 1'b0;
        ram_waddr  = clr_addr_reg;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        op_a       = '0;
        op_b       = '0;
        fin_miss   = 1'b0;
        fin_hit    = 1'b0;
        walk_init  = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            vgrt_pkg::ST_CLEAR:
            begin
                stat.clearing = 1'b1;
                ram_we        = 1'b1;
                if (clr_addr_reg == AW'(MAP_DEPTH - 1))
                begin
                    state_next = vgrt_pkg::ST_IDLE;
                end
            end
            vgrt_pkg::ST_IDLE:
            begin
                if (fe.valid)
                begin
                    stat.pop = 1'b1;
                    if (fe.entry.item.operation == vgrt_pkg::OP_RAY)
                    begin
                        state_next = vgrt_pkg::ST_SQ;
                    end
                    else if (fe.entry.wr_ok)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(32'(fe.entry.item.voxel_address));
                        ram_wdata = wr_word;
                    end
                end
            end
            vgrt_pkg::ST_SQ:
            begin
                if (k_reg != 2'd3)
                begin
                    op_a = 32'(ad_k);
                    op_b = 32'(ad_k);
                end
                else if (sumsq_sum == 32'd0)
                begin
                    fin_miss   = 1'b1;
                    state_next = vgrt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = vgrt_pkg::ST_SQRT_GO;
                end
            end
            vgrt_pkg::ST_SQRT_GO:
            begin
                ds_go      = 1'b1;
                ds_mode    = vgrt_pkg::DS_SQRT;
                state_next = vgrt_pkg::ST_SQRT_W;
            end
            vgrt_pkg::ST_SQRT_W:
            begin
                if (ds_done)
                begin
                    state_next = vgrt_pkg::ST_CDIV;
                end
            end
            vgrt_pkg::ST_CDIV:
            begin
                ds_go      = 1'b1;
                ds_num     = 48'(q_abs);
                ds_den     = 32'(cs);
                state_next = vgrt_pkg::ST_CDIV_W;
            end
            vgrt_pkg::ST_CDIV_W:
            begin
                if (ds_done)
                begin
                    if (!dir_zero)
                    begin
                        state_next = vgrt_pkg::ST_MULA;
                    end
                    else if (k_reg == 2'd2)
                    begin
                        walk_init  = 1'b1;
                        state_next = vgrt_pkg::ST_W_CHK;
                    end
                    else
                    begin
                        state_next = vgrt_pkg::ST_CDIV;
                    end
                end
            end
            vgrt_pkg::ST_MULA:
            begin
                op_a       = 32'(a_reg);
                op_b       = lenq_reg;
                state_next = vgrt_pkg::ST_TN;
            end
            vgrt_pkg::ST_TN:
            begin
                ds_go      = 1'b1;
                ds_num     = prod_reg[63:16];
                ds_den     = 32'(ad_k);
                state_next = vgrt_pkg::ST_TN_W;
            end
            vgrt_pkg::ST_TN_W:
            begin
                if (ds_done)
                begin
                    state_next = vgrt_pkg::ST_MULS;
                end
            end
            vgrt_pkg::ST_MULS:
            begin
                op_a       = 32'(cs);
                op_b       = lenq_reg;
                state_next = vgrt_pkg::ST_TS;
            end
            vgrt_pkg::ST_TS:
            begin
                ds_go      = 1'b1;
                ds_num     = prod_reg[63:16];
                ds_den     = 32'(ad_k);
                state_next = vgrt_pkg::ST_TS_W;
            end
            vgrt_pkg::ST_TS_W:
            begin
                if (ds_done)
                begin
                    if (k_reg == 2'd2)
                    begin
                        walk_init  = 1'b1;
                        state_next = vgrt_pkg::ST_W_CHK;
                    end
                    else
                    begin
                        state_next = vgrt_pkg::ST_CDIV;
                    end
                end
            end
            vgrt_pkg::ST_W_CHK:
            begin
                if (guard_reg == GW'(STEP_GUARD))
                begin
                    fin_miss   = 1'b1;
                    state_next = vgrt_pkg::ST_DONE;
                end
                else if (in_grid)
                begin
                    state_next = vgrt_pkg::ST_W_RD;
                end
                else
                begin
                    state_next = vgrt_pkg::ST_W_SEL;
                end
            end
            vgrt_pkg::ST_W_RD:
            begin
                ram_re     = 1'b1;
                state_next = vgrt_pkg::ST_W_TEST;
            end
            vgrt_pkg::ST_W_TEST:
            begin
                if (ram_rdata[RW-1])
                begin
                    fin_hit    = 1'b1;
                    state_next = vgrt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = vgrt_pkg::ST_W_SEL;
                end
            end
            vgrt_pkg::ST_W_SEL:
            begin
                if (t_reg > TW'(maxr_reg) || leave)
                begin
                    fin_miss   = 1'b1;
                    state_next = vgrt_pkg::ST_DONE;
                end
                else
                begin
                    state_next = vgrt_pkg::ST_W_ADV;
                end
            end
            vgrt_pkg::ST_W_ADV:
            begin
                state_next = vgrt_pkg::ST_W_CHK;
            end
            vgrt_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = vgrt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vgrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vgrt_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == vgrt_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        case (state_reg)
            vgrt_pkg::ST_IDLE:
            begin
                pos_reg[0] <= fe.entry.item.ray_origin_x;
                pos_reg[1] <= fe.entry.item.ray_origin_y;
                pos_reg[2] <= fe.entry.item.ray_origin_z;
                dir_reg[0] <= fe.entry.item.ray_dir_x;
                dir_reg[1] <= fe.entry.item.ray_dir_y;
                dir_reg[2] <= fe.entry.item.ray_dir_z;
                maxr_reg   <= fe.entry.item.max_range;
                sumsq_reg  <= '0;
                k_reg      <= 2'd0;
            end
            vgrt_pkg::ST_SQ:
            begin
                sumsq_reg <= sumsq_sum;
                k_reg     <= (k_reg == 2'd3) ? 2'd0 : k_reg + 2'd1;
            end
            vgrt_pkg::ST_SQRT_W:
            begin
                if (ds_done)
                begin
                    lenq_reg <= ds_root;
                end
            end
            vgrt_pkg::ST_CDIV_W:
            begin
                if (ds_done)
                begin
                    cell_reg[k_reg] <= c_val;
                    a_reg           <= a_val;
                    if (dir_zero)
                    begin
                        tn_reg[k_reg] <= vgrt_pkg::T_INF;
                        ts_reg[k_reg] <= vgrt_pkg::T_INF;
                        k_reg         <= k_reg + 2'd1;
                    end
                end
            end
            vgrt_pkg::ST_TN_W:
            begin
                if (ds_done)
                begin
                    tn_reg[k_reg] <= TW'(ds_quo);
                end
            end
            vgrt_pkg::ST_TS_W:
            begin
                if (ds_done)
                begin
                    ts_reg[k_reg] <= TW'(ds_quo);
                    k_reg         <= k_reg + 2'd1;
                end
            end
            vgrt_pkg::ST_W_CHK:
            begin
                addr_reg <= idx[AW-1:0];
            end
            vgrt_pkg::ST_W_SEL:
            begin
                ax_reg <= ax_val;
            end
            vgrt_pkg::ST_W_ADV:
            begin
                t_reg     <= tn_reg[ax_reg];
                guard_reg <= guard_reg + GW'(1);
                if (dir_reg[ax_reg] > 16'sd0)
                begin
                    cell_reg[ax_reg] <= cell_reg[ax_reg] + CW'(1);
                end
                else
                begin
                    cell_reg[ax_reg] <= cell_reg[ax_reg] - CW'(1);
                end
                tn_reg[ax_reg] <= (tn_sum > {1'b0, vgrt_pkg::T_CAP}) ?
                                  vgrt_pkg::T_CAP : tn_sum[TW-1:0];
            end
            default:
            begin
            end
        endcase
        if (walk_init)
        begin
            t_reg     <= '0;
            guard_reg <= '0;
        end
        if (fin_miss)
        begin
            hit_reg  <= 1'b0;
            dist_reg <= maxr_reg;
            tex_reg  <= 8'd0;
        end
        if (fin_hit)
        begin
            hit_reg  <= 1'b1;
            dist_reg <= (t_reg > TW'(vgrt_pkg::DIST_MAX)) ? vgrt_pkg::DIST_MAX : t_reg[30:0];
            tex_reg  <= rd_tex;
        end
    end

    assign result.hit         = hit_reg;
    assign result.distance    = dist_reg;
    assign result.hit_texture = tex_reg;

    vgrt_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (ds_go),
        .mode  (ds_mode),
        .num   (ds_num),
        .den   (ds_den),
        .rad   (sumsq_reg),
        .done  (ds_done),
        .quo   (ds_quo),
        .rem   (ds_rem),
        .root  (ds_root)
    );

    vgrt_ram #(
        .WIDTH (RW),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    a_tex_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.hit |-> result.hit_texture == 8'd0)
        else $error("texture reported without a hit");
    a_miss_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.hit |-> result.distance == maxr_reg)
        else $error("miss distance differs from range limit");
    a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vgrt_pkg::ST_W_ADV |-> guard_reg < GW'(STEP_GUARD))
        else $error("walk stepped past the step guard");
    a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !stat.pop)
        else $error("queue popped during clearing pass");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the voxel grid ray traversal block.
module testbench;
    import vgrt_pkg::*;

    localparam int  MAP_DEPTH   = GRID_X_MAX_DEF * GRID_Y_MAX_DEF * GRID_Z_MAX_DEF;
    localparam int  CYCLE_LIMIT = 40_000_000;
    localparam longint TCAP     = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint TINF     = 64'h4000_0000_0000_0000;

    class ray_scoreboard;
        bit             solid_map [MAP_DEPTH];
        logic [7:0]     texture_map [MAP_DEPTH];
        longint         cell_size, grid_org [3];
        longint         grid_cells [3];
        result_t        expected_hits [$];
        int             mismatches, rays, hits;

        function new();
            foreach (solid_map[i]) solid_map[i] = 0;
            foreach (texture_map[i]) texture_map[i] = '0;
            cell_size = 65536;
            grid_org = '{0, 0, 0};
            grid_cells = '{128, 128, 64};
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] data);
            case (idx)
                CFG_CELL_SIZE: cell_size = data[30:0];
                CFG_ORIGIN_X:  grid_org[0] = longint'(signed'(data));
                CFG_ORIGIN_Y:  grid_org[1] = longint'(signed'(data));
                CFG_ORIGIN_Z:  grid_org[2] = longint'(signed'(data));
                CFG_CELLS_X:   grid_cells[0] = data[7:0];
                CFG_CELLS_Y:   grid_cells[1] = data[7:0];
                CFG_CELLS_Z:   grid_cells[2] = data[6:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'h1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint cap(longint unsigned v);
            return (v > longint'(TCAP)) ? TCAP : longint'(v);
        endfunction

        function result_t trace_ray(item_t it);
            longint unsigned sumsq, lenq, maxr, t, ad, den, a, idx;
            longint  cs, q, r;
            longint  cidx [3], tn [3], ts [3], lim [3], p [3], d [3];
            int      sg [3];
            int      ax, g;
            bit      in_grid, leaving;
            result_t res;
            maxr = it.max_range;
            t = 0;
            res.hit = 0;
            res.distance = it.max_range;
            res.hit_texture = '0;
            cs = (cell_size == 0) ? 1 : cell_size;
            lim[0] = (grid_cells[0] > GRID_X_MAX_DEF) ? GRID_X_MAX_DEF : grid_cells[0];
            lim[1] = (grid_cells[1] > GRID_Y_MAX_DEF) ? GRID_Y_MAX_DEF : grid_cells[1];
            lim[2] = (grid_cells[2] > GRID_Z_MAX_DEF) ? GRID_Z_MAX_DEF : grid_cells[2];
            p[0] = it.ray_origin_x;
            p[1] = it.ray_origin_y;
            p[2] = it.ray_origin_z;
            d[0] = it.ray_dir_x;
            d[1] = it.ray_dir_y;
            d[2] = it.ray_dir_z;
            sumsq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
            if (sumsq == 0) return res;
            lenq = root(sumsq << 32);
            for (int k = 0; k < 3; k++) begin
                q = p[k] - grid_org[k];
                if (q >= 0) cidx[k] = q / cs;
                else cidx[k] = -((-q + cs - 1) / cs);
                r = q - cidx[k] * cs;
                sg[k] = (d[k] > 0) ? 1 : ((d[k] < 0) ? -1 : 0);
                if (sg[k] == 0) begin
                    tn[k] = TINF;
                    ts[k] = TINF;
                end
                else begin
                    ad = (d[k] < 0) ? -d[k] : d[k];
                    den = ad << 16;
                    a = (sg[k] > 0) ? cs - r : r;
                    tn[k] = cap((a * lenq) / den);
                    ts[k] = cap((longint'(cs) * lenq) / den);
                end
            end
            for (g = 0; g < STEP_GUARD_DEF; g++) begin
                in_grid = 1;
                for (int k = 0; k < 3; k++)
                    if (cidx[k] < 0 || cidx[k] >= lim[k]) in_grid = 0;
                if (in_grid) begin
                    idx = (cidx[2] * GRID_Y_MAX_DEF + cidx[1]) * GRID_X_MAX_DEF + cidx[0];
                    if (solid_map[idx]) begin
                        res.hit = 1;
                        res.distance = (t > 64'h7FFF_FFFF) ? DIST_MAX : t[30:0];
                        res.hit_texture = texture_map[idx];
                        return res;
                    end
                end
                if (t > maxr) break;
                leaving = 0;
                for (int k = 0; k < 3; k++)
                    if ((cidx[k] < 0 && sg[k] <= 0) || (cidx[k] >= lim[k] && sg[k] >= 0))
                        leaving = 1;
                if (leaving) break;
                if (tn[0] < tn[1] && tn[0] < tn[2]) ax = 0;
                else if (tn[1] < tn[2]) ax = 1;
                else ax = 2;
                t = tn[ax];
                cidx[ax] += sg[ax];
                tn[ax] = cap(tn[ax] + ts[ax]);
            end
            return res;
        endfunction

        function void note_request(item_t it);
            result_t r;
            if (it.operation == OP_WRITE) begin
                solid_map[it.voxel_address] = it.voxel_solid;
                texture_map[it.voxel_address] = it.voxel_texture;
            end
            else begin
                r = trace_ray(it);
                rays++;
                if (r.hit) hits++;
                expected_hits = {expected_hits, r};
            end
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hit=%0d dist=%0d tex=%0d",
                             got.hit, got.distance, got.hit_texture);
                return;
            end
            exp_r = expected_hits.pop_front();
            if (got.hit !== exp_r.hit || got.distance !== exp_r.distance ||
                got.hit_texture !== exp_r.hit_texture) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected hit=%0d dist=%0d tex=%0d, got %0d %0d %0d",
                             exp_r.hit, exp_r.distance, exp_r.hit_texture,
                             got.hit, got.distance, got.hit_texture);
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    ray_scoreboard sb;
    int          cycles;
    bit          no_idle;

    voxel_grid_ray_traversal dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic set_grid(logic [31:0] cs, logic [31:0] ox, logic [31:0] oy,
                            logic [31:0] oz, logic [7:0] nx, logic [7:0] ny, logic [6:0] nz);
        write_reg(CFG_CELL_SIZE, cs);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_CELLS_X, 32'(nx));
        write_reg(CFG_CELLS_Y, 32'(ny));
        write_reg(CFG_CELLS_Z, 32'(nz));
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send(item_t it);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(it);
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            if ($urandom_range(9) == 0) repeat ($urandom_range(1, 400)) @(negedge clk);
            else repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // Hold off until every ray has answered, then let a stray write settle.
    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        repeat (20) @(negedge clk);
    endtask

    function automatic item_t noise_item();
        item_t it;
        it.operation     = 1'($urandom);
        it.voxel_address = 20'($urandom);
        it.voxel_solid   = 1'($urandom);
        it.voxel_texture = 8'($urandom);
        it.ray_origin_x  = 32'($urandom);
        it.ray_origin_y  = 32'($urandom);
        it.ray_origin_z  = 32'($urandom);
        it.ray_dir_x     = 16'($urandom);
        it.ray_dir_y     = 16'($urandom);
        it.ray_dir_z     = 16'($urandom);
        it.max_range     = 31'($urandom);
        return it;
    endfunction

    function automatic int addr_of(int x, int y, int z);
        return (z * GRID_Y_MAX_DEF + y) * GRID_X_MAX_DEF + x;
    endfunction

    function automatic item_t voxel_write(int addr, bit solid, logic [7:0] tex);
        item_t it;
        it = noise_item();
        it.operation     = OP_WRITE;
        it.voxel_address = 20'(addr);
        it.voxel_solid   = solid;
        it.voxel_texture = tex;
        return it;
    endfunction

    function automatic item_t ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                  logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                                  logic [30:0] maxr);
        item_t it;
        it = noise_item();
        it.operation    = OP_RAY;
        it.ray_origin_x = ox;
        it.ray_origin_y = oy;
        it.ray_origin_z = oz;
        it.ray_dir_x    = dx;
        it.ray_dir_y    = dy;
        it.ray_dir_z    = dz;
        it.max_range    = maxr;
        return it;
    endfunction

    function automatic logic [15:0] rand_dir();
        return ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
    endfunction

    // Random request aimed at the populated corner of the grid in use.
    function automatic item_t random_request();
        item_t  it;
        longint cs, span, m [3], pos [3];
        int     c;
        cs = (sb.cell_size == 0) ? 1 : sb.cell_size;
        m[0] = (sb.grid_cells[0] == 0) ? 4 : ((sb.grid_cells[0] > 16) ? 16 : sb.grid_cells[0]);
        m[1] = (sb.grid_cells[1] == 0) ? 4 : ((sb.grid_cells[1] > 16) ? 16 : sb.grid_cells[1]);
        m[2] = (sb.grid_cells[2] == 0) ? 4 : ((sb.grid_cells[2] > 16) ? 16 : sb.grid_cells[2]);
        if ($urandom_range(99) < 35)
        begin
            if ($urandom_range(99) < 70)
                return voxel_write(addr_of(int'($urandom_range(m[0] - 1)),
                                           int'($urandom_range(m[1] - 1)),
                                           int'($urandom_range(m[2] - 1))),
                                   $urandom_range(99) < 60, 8'($urandom));
            it = noise_item();
            it.operation = OP_WRITE;
            return it;
        end
        span = 16 * cs;
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        if ($urandom_range(99) < 20)
        begin
            // Wild origin; keep the range short so the walk stays brief.
            it = noise_item();
            it.operation = OP_RAY;
            it.max_range = 31'($urandom_range(0, int'(span)));
            return it;
        end
        for (int k = 0; k < 3; k++)
        begin
            c = int'($urandom_range(0, m[k] + 1)) - 1;
            pos[k] = sb.grid_org[k] + c * cs + ($urandom % cs);
        end
        return ray(pos[0][31:0], pos[1][31:0], pos[2][31:0], rand_dir(), rand_dir(), rand_dir(),
                   ($urandom_range(1)) ? 31'($urandom) : 31'($urandom_range(0, int'(span))));
    endfunction

    task automatic random_phase(int count, int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at) drain();
            send(random_request());
        end
        drain();
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] HALF = 32'h0000_8000;

    initial
    begin
        sb = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_idle   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_grid(ONE, 0, 0, 0, 8'd128, 8'd128, 7'd64);
        send(voxel_write(0, 1, 8'hFF));
        send(voxel_write(MAP_DEPTH - 1, 1, 8'h5A));
        send(voxel_write(addr_of(5, 3, 2), 1, 8'h33));
        send(voxel_write(addr_of(0, 1, 10), 1, 8'h11));
        send(voxel_write(addr_of(1, 0, 10), 1, 8'h22));
        // solid start cell
        send(ray(HALF, HALF, HALF, 16'd1, 16'd0, 16'd0, 31'(100 * ONE)));
        // zero direction
        send(ray(HALF, HALF, HALF, 16'd0, 16'd0, 16'd0, 31'd12345));
        send(ray(HALF, 3 * ONE + HALF, 2 * ONE + HALF, 16'd1, 16'd0, 16'd0, 31'(100 * ONE)));
        // range runs out before the solid voxel
        send(ray(HALF, 3 * ONE + HALF, 2 * ONE + HALF, 16'd7, 16'd0, 16'd0, 31'(ONE)));
        // solid voxel entered just past the range
        send(ray(HALF, 3 * ONE + HALF, 2 * ONE + HALF, 16'd1, 16'd0, 16'd0,
                 31'(4 * ONE + 32'h4000)));
        // ties: x/y, y/z and all three
        send(ray(HALF, HALF, 10 * ONE + HALF, 16'd3, 16'd3, 16'd0, 31'(50 * ONE)));
        send(ray(HALF, HALF, 20 * ONE + HALF, 16'd0, 16'd9, 16'd9, 31'(50 * ONE)));
        send(ray(HALF, HALF, 30 * ONE + HALF, 16'd5, 16'd5, 16'd5, 31'(50 * ONE)));
        send(ray(64 * ONE, 64 * ONE, 32 * ONE, 16'h8000, 16'h7FFF, 16'h8000, 31'h7FFF_FFFF));
        send(ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'd1, 16'hFFFF, 16'd0, 31'd0));
        send(ray(2 * ONE, 2 * ONE, 2 * ONE, 16'd2, 16'd1, 16'd3, 31'd0));
        send(voxel_write(0, 0, 8'h80));
        send(ray(HALF, HALF, HALF, 16'd1, 16'd0, 16'd0, 31'(3 * ONE)));
        // already outside and moving away
        send(ray(32'hFFFF_0000, HALF, HALF, 16'hFFF0, 16'd0, 16'd0, 31'(100 * ONE)));
        send(ray(127 * ONE + HALF, 127 * ONE + HALF, 63 * ONE + HALF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 31'h7FFF_FFFF));
        drain();

        // Tiny cells far below the grid: the walk ends on the step guard.
        set_grid(32'd1, 0, 0, 0, 8'd128, 8'd128, 7'd64);
        send(ray(-32'sd200000, 0, 0, 16'd1, 16'd0, 16'd0, 31'h7FFF_FFFF));
        drain();

        set_grid(ONE, 0, 0, 0, 8'd8, 8'd8, 7'd8);
        random_phase(150, -1);
        set_grid(32'd0, 32'($urandom_range(0, 255)), -32'sd77, 32'd9, 8'd4, 8'd6, 7'd3);
        random_phase(150, -1);
        set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 8'd2, 8'd2, 7'd1);
        random_phase(150, -1);
        no_idle = 1;
        set_grid(32'd4096, $urandom, $urandom, $urandom, 8'd255, 8'd255, 7'd127);
        random_phase(150, -1);
        no_idle = 0;
        set_grid(32'($urandom_range(1 << 14, 1 << 18)), -32'sd300000, 32'd5000, 32'd0,
                 8'd0, 8'd5, 7'd5);
        random_phase(150, -1);
        set_grid(32'($urandom_range(1 << 12, 1 << 20)), 32'($urandom_range(0, 1 << 20)),
                 32'd0, -32'sd65536, 8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)),
                 7'($urandom_range(1, 16)));
        random_phase(150, 60);
        set_grid(ONE, 0, 0, 0, 8'd128, 8'd128, 7'd64);
        random_phase(130, -1);

        repeat (50) @(negedge clk);
        $display("covered %0d rays (%0d hits) across nine grid settings incl. zero,",
                 sb.rays, sb.hits);
        $display("oversize and extreme cell sizes, counts and origins");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/vgrt_pkg.sv
rtl/core/vgrt_ram.sv
rtl/core/vgrt_divsqrt.sv
rtl/core/vgrt_front.sv
rtl/core/vgrt_back.sv
rtl/core/voxel_grid_ray_traversal.sv
tb/testbench.sv
